// ===== rtl/core/frx_pkg.sv =====
// ----------------------------------------------------------------------------
// frx_pkg
// Shared constants, register indexes, state and control types of the
// header-synchronised frame receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

  localparam int FRAME_LEN_DEF = 35;
  localparam int TAG_INDEX_DEF = 14;

  localparam int BYTE_W    = 8;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'd0;
  localparam logic [BYTE_W-1:0] TAG_RST    = 8'd20;
  localparam logic [BYTE_W-1:0] LIMIT_RST  = 8'd80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER = 2'd0,
    CFG_TAG    = 2'd1,
    CFG_LIMIT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic step;
    logic rd_issue;
    logic rd_advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_good;
    logic rd_last;
  } dp_sts_t;

endpackage

// ===== rtl/core/frx_in_if.sv =====
// ----------------------------------------------------------------------------
// frx_in_if
// Received byte channel: valid, ready and one byte.
// ----------------------------------------------------------------------------
interface frx_in_if
  import frx_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/frx_out_if.sv =====
// ----------------------------------------------------------------------------
// frx_out_if
// Frame byte channel: valid, ready, byte, position and last flag.
// ----------------------------------------------------------------------------
interface frx_out_if
  import frx_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [IDX_W-1:0]  byte_index;
  logic              frame_last;

  modport source (output valid, output data_byte, output byte_index, output frame_last,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_index, input frame_last,
                  output ready);
endinterface

// ===== rtl/core/frx_ram.sv =====
// ----------------------------------------------------------------------------
// frx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 35
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/frx_ctrl.sv =====
// ----------------------------------------------------------------------------
// frx_ctrl
// Controller: byte intake, then readout of a good frame one byte at a time.
// ----------------------------------------------------------------------------
module frx_ctrl
  import frx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (in_valid && sts.frame_good) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = sts.rd_last ? ST_RUN : ST_RD;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd.step       = 1'b0;
    cmd.rd_issue   = 1'b0;
    cmd.rd_advance = 1'b0;
    case (state)
      ST_RUN: begin
        in_ready = 1'b1;
        cmd.step = in_valid;
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
      end
      ST_OUT: begin
        out_valid      = 1'b1;
        cmd.rd_advance = out_ready && !sts.rd_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(state))
    else $error("stalled result dropped");

  a_good_starts_read: assert property (@(posedge clk) disable iff (rst)
    cmd.step && sts.frame_good |=> state == ST_RD)
    else $error("good frame not read out");

endmodule

// ===== rtl/core/frx_dpath.sv =====
// ----------------------------------------------------------------------------
// frx_dpath
// Datapath: configuration, hunt and lock state, checksum, frame store and
// readout index.
// ----------------------------------------------------------------------------
module frx_dpath
  import frx_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF,
  parameter int TAG_INDEX = TAG_INDEX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  ctrl_cmd_t            cmd,
  output dp_sts_t              sts,
  output logic [BYTE_W-1:0]    data_byte,
  output logic [IDX_W-1:0]     byte_index,
  output logic                 frame_last
);

  localparam int AW = $clog2(FRAME_LEN);
  localparam logic [AW-1:0] LAST_POS = AW'(FRAME_LEN - 1);
  localparam logic [AW-1:0] TAG_POS  = AW'(TAG_INDEX);

  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] tag_offset;
  logic [BYTE_W-1:0] byte_limit;

  logic              locked;
  logic              locked_next;
  logic [AW-1:0]     pos;
  logic [AW-1:0]     pos_next;
  logic [BYTE_W-1:0] bytes_seen;
  logic [BYTE_W-1:0] bytes_seen_next;
  logic [BYTE_W-1:0] xor_accum;
  logic [BYTE_W-1:0] xor_accum_next;
  logic [AW-1:0]     idx;

  logic [BYTE_W-1:0] seen_inc;
  logic              hdr_match;
  logic              frame_end;
  logic              over_limit;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RST;
      tag_offset  <= TAG_RST;
      byte_limit  <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER: header_byte <= cfg_data;
        CFG_TAG:    tag_offset  <= cfg_data;
        CFG_LIMIT:  byte_limit  <= cfg_data;
        default:    header_byte <= header_byte;
      endcase
    end
  end

  always_comb begin
    seen_inc   = bytes_seen + 8'd1;
    hdr_match  = !locked && (rx_byte == header_byte);
    frame_end  = locked && (pos == LAST_POS);
    over_limit = seen_inc > byte_limit;

    sts.frame_good = frame_end && (xor_accum == rx_byte);
    sts.rd_last    = (idx == LAST_POS);

    locked_next     = locked;
    pos_next        = pos;
    xor_accum_next  = xor_accum;
    bytes_seen_next = (frame_end || over_limit) ? '0 : seen_inc;
    if (hdr_match) begin
      locked_next    = 1'b1;
      pos_next       = AW'(1);
      xor_accum_next = '0;
    end else if (locked) begin
      pos_next = pos + AW'(1);
      if (!frame_end) begin
        xor_accum_next = xor_accum ^ rx_byte;
      end
    end
    if (frame_end || over_limit) begin
      locked_next = 1'b0;
      pos_next    = '0;
    end

    ram_we    = cmd.step && (locked || hdr_match);
    ram_waddr = locked ? pos : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locked     <= 1'b0;
      pos        <= '0;
      bytes_seen <= '0;
      xor_accum  <= '0;
      idx        <= '0;
    end else begin
      if (cmd.step) begin
        locked     <= locked_next;
        pos        <= pos_next;
        bytes_seen <= bytes_seen_next;
        xor_accum  <= xor_accum_next;
        idx        <= '0;
      end else if (cmd.rd_advance) begin
        idx <= idx + AW'(1);
      end
    end
  end

  frx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx_byte),
    .re    (cmd.rd_issue),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign data_byte  = (idx == TAG_POS) ? ram_rdata + tag_offset : ram_rdata;
  assign byte_index = IDX_W'(idx);
  assign frame_last = sts.rd_last;

  a_hunt_pos: assert property (@(posedge clk) disable iff (rst)
    !locked |-> pos == '0)
    else $error("position set while hunting");

  a_lock_pos: assert property (@(posedge clk) disable iff (rst)
    locked |-> pos != '0)
    else $error("locked at header position");

  a_advance_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_advance |=> idx != '0)
    else $error("readout index wrapped");

endmodule

// ===== rtl/core/header_sync_xor_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// header_sync_xor_frame_receiver
// Header-synchronised fixed-length frame receiver with XOR checksum.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the receiver hunts or fills a frame.
// When the byte that completes a checksum-good frame is taken, the frame is
// read back from the frame memory and sent out as FRAME_LEN transfers, each a
// registered memory read followed by presenting the byte, which is held while
// the output stalls; no byte is taken during this readout. Bad frames and
// resyncs cost nothing beyond their input bytes. The frame memory needs no
// clearing pass.
module header_sync_xor_frame_receiver
  import frx_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF,
  parameter int TAG_INDEX = TAG_INDEX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  frx_in_if.sink               rx,
  frx_out_if.source            tx
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  frx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  frx_dpath #(
    .FRAME_LEN (FRAME_LEN),
    .TAG_INDEX (TAG_INDEX)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_byte    (rx.rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .data_byte  (tx.data_byte),
    .byte_index (tx.byte_index),
    .frame_last (tx.frame_last)
  );

endmodule

// ===== tb/header_sync_xor_frame_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// header_sync_xor_frame_receiver_tb
// Self-checking bench for the header-synchronised XOR frame receiver.
// ----------------------------------------------------------------------------
// Received bytes go in over the byte channel with random gaps. A local copy of
// the deframer (hunt, lock, fill, checksum, tag adjust, byte-count resync)
// predicts every frame byte that should come out. The output side stalls at
// random and each transfer is compared field by field with the oldest
// prediction. Directed tests cover reset settings, bad checksums, the resync
// limit at its edges and the wrapping byte count; random traffic follows
// under several register settings.
// ----------------------------------------------------------------------------
module header_sync_xor_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frx_pkg::*;

  localparam int FRAME_LEN       = FRAME_LEN_DEF;
  localparam int TAG_INDEX       = TAG_INDEX_DEF;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int REPORT_MAX      = 10;
  localparam int RANDOM_PHASES   = 3;
  localparam int PHASE_ITEMS     = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              frame_last;
  } frame_beat_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  frx_in_if  rx_if ();
  frx_out_if tx_if ();

  header_sync_xor_frame_receiver u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_if),
    .tx        (tx_if)
  );

  // deframer copy
  logic [BYTE_W-1:0] hdr_reg;
  logic [BYTE_W-1:0] tag_reg;
  logic [BYTE_W-1:0] limit_reg;
  bit                in_frame;
  int                fill_pos;
  logic [BYTE_W-1:0] seen_cnt;
  logic [BYTE_W-1:0] xor_sum;
  logic [BYTE_W-1:0] frame_buf [FRAME_LEN];
  frame_beat_t       pending_beats [$];

  int mismatches;
  int rx_count;
  int beats_checked;
  int frames_checked;
  int reg_writes;
  int drain_pauses;
  int sink_hold;
  int idle_cycles;
  bit quiet_mode;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void drop_lock();
    in_frame = 1'b0;
    fill_pos = 0;
    seen_cnt = '0;
  endfunction

  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    frame_beat_t beat;
    int          k;
    seen_cnt = seen_cnt + 8'd1;
    if (!in_frame) begin
      if (b == hdr_reg) begin
        in_frame     = 1'b1;
        frame_buf[0] = b;
        fill_pos     = 1;
        xor_sum      = '0;
      end
    end else begin
      if (fill_pos < FRAME_LEN) begin
        frame_buf[fill_pos] = b;
        if (fill_pos >= 1 && fill_pos <= FRAME_LEN - 2) begin
          xor_sum = xor_sum ^ b;
        end
        fill_pos = fill_pos + 1;
      end else begin
        fill_pos = FRAME_LEN;
      end
      if (fill_pos >= FRAME_LEN) begin
        if (xor_sum == frame_buf[FRAME_LEN-1]) begin
          for (k = 0; k < FRAME_LEN; k++) begin
            beat.data_byte  = (k == TAG_INDEX) ? frame_buf[k] + tag_reg : frame_buf[k];
            beat.byte_index = IDX_W'(k);
            beat.frame_last = (k == FRAME_LEN - 1);
            pending_beats.push_back(beat);
          end
        end
        drop_lock();
      end
    end
    if (seen_cnt > limit_reg) begin
      drop_lock();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_mismatch(input string msg);
    if (mismatches < REPORT_MAX) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatches++;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = quiet_mode ? 0 : pick_gap();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    deframe_byte(b);
    rx_count++;
  endtask

  task automatic send_noise(input int n, input bit allow_header);
    logic [BYTE_W-1:0] b;
    int                i;
    for (i = 0; i < n; i++) begin
      b = BYTE_W'($urandom);
      if (!allow_header && b == hdr_reg) begin
        b = ~b;
      end
      send_byte(b);
    end
  endtask

  task automatic send_frame(input bit corrupt, input bit extremes);
    logic [BYTE_W-1:0] body [FRAME_LEN];
    logic [BYTE_W-1:0] chk;
    int                k;
    body[0] = hdr_reg;
    chk     = '0;
    for (k = 1; k < FRAME_LEN - 1; k++) begin
      if (!extremes) begin
        body[k] = BYTE_W'($urandom);
      end else if (k == 1) begin
        body[k] = hdr_reg;
      end else if (k == TAG_INDEX) begin
        body[k] = 8'hF0;
      end else begin
        body[k] = (k % 2) ? 8'hFF : 8'h00;
      end
      chk = chk ^ body[k];
    end
    body[FRAME_LEN-1] = corrupt ? chk ^ BYTE_W'($urandom_range(1, 255)) : chk;
    for (k = 0; k < FRAME_LEN; k++) begin
      send_byte(body[k]);
    end
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // call only after settle
  task automatic apply_settings(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] tag,
                                input logic [BYTE_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEADER;
    cfg_data  <= hdr;
    @(posedge clk);
    cfg_index <= CFG_TAG;
    cfg_data  <= tag;
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hdr_reg    = hdr;
    tag_reg    = tag;
    limit_reg  = lim;
    reg_writes += 3;
  endtask

  task automatic test_reset_values();
    send_noise(2, 1'b0);
    send_frame(1'b0, 1'b1);
    settle();
  endtask

  task automatic test_bad_checksum();
    send_frame(1'b1, 1'b0);
    send_frame(1'b0, 1'b0);
    settle();
  endtask

  task automatic test_limit_edges();
    apply_settings(8'h5A, 8'h80, 8'd1);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h5A);
    send_byte(8'h00);
    settle();
    apply_settings(8'h5A, 8'h80, 8'd34);
    send_frame(1'b0, 1'b0);
    settle();
    apply_settings(8'h5A, 8'h80, 8'd33);
    send_frame(1'b0, 1'b0);
    settle();
    apply_settings(8'hA5, 8'h01, 8'd20);
    send_byte(8'hA5);
    send_noise(24, 1'b0);
    settle();
  endtask

  task automatic test_counter_wrap();
    apply_settings(8'hFF, 8'hFF, 8'd255);
    send_noise(225, 1'b0);
    send_frame(1'b0, 1'b0);
    settle();
  endtask

  task automatic test_random_traffic();
    int phase;
    int start;
    int sel;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       apply_settings(8'hFF, 8'hFF, 8'd255);
        1:       apply_settings(8'h00, 8'h00, 8'd38);
        default: apply_settings(BYTE_W'($urandom), BYTE_W'($urandom),
                                BYTE_W'($urandom_range(40, 254)));
      endcase
      quiet_mode = (phase == 2);
      start      = rx_count;
      while (rx_count - start < PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          send_noise($urandom_range(0, 3), 1'b0);
          send_frame(1'b0, 1'b0);
        end else if (sel < 75) begin
          send_frame(1'b1, 1'b0);
        end else if (sel < 85) begin
          send_noise($urandom_range(1, 6), 1'b1);
        end else if (sel < 95) begin
          send_byte(hdr_reg);
          send_noise($urandom_range(1, 20), 1'b1);
        end else begin
          drain();
          drain_pauses++;
        end
      end
      settle();
      quiet_mode = 1'b0;
    end
  endtask

  always @(posedge clk) begin : sink_side
    frame_beat_t got;
    frame_beat_t want;
    int          r;
    if (!rst && tx_if.valid && tx_if.ready) begin
      got.data_byte  = tx_if.data_byte;
      got.byte_index = tx_if.byte_index;
      got.frame_last = tx_if.frame_last;
      beats_checked++;
      if (pending_beats.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer: data %02h index %0d last %0b",
                                got.data_byte, got.byte_index, got.frame_last));
      end else begin
        want = pending_beats.pop_front();
        if (want.frame_last) frames_checked++;
        if (got.data_byte !== want.data_byte || got.byte_index !== want.byte_index ||
            got.frame_last !== want.frame_last) begin
          note_mismatch($sformatf(
            "expected data %02h index %0d last %0b, got data %02h index %0d last %0b",
            want.data_byte, want.byte_index, want.frame_last,
            got.data_byte, got.byte_index, got.frame_last));
        end
      end
    end
    if (sink_hold > 0) begin
      tx_if.ready <= 1'b0;
      sink_hold--;
    end else if (quiet_mode) begin
      tx_if.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        tx_if.ready <= 1'b1;
      end else if (r < 96) begin
        tx_if.ready <= 1'b0;
        sink_hold = $urandom_range(0, 2);
      end else begin
        tx_if.ready <= 1'b0;
        sink_hold = $urandom_range(10, 30);
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    @(negedge rst);
    while (idle_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("No transfer for %0d cycles, %0d frame bytes still due",
             WATCHDOG_CYCLES, pending_beats.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_HEADER;
    cfg_data      <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    hdr_reg        = HEADER_RST;
    tag_reg        = TAG_RST;
    limit_reg      = LIMIT_RST;
    xor_sum        = '0;
    quiet_mode     = 1'b0;
    sink_hold      = 0;
    mismatches     = 0;
    rx_count       = 0;
    beats_checked  = 0;
    frames_checked = 0;
    reg_writes     = 0;
    drain_pauses   = 0;
    drop_lock();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_bad_checksum();
    test_limit_edges();
    test_counter_wrap();
    test_random_traffic();

    repeat (3 * FRAME_LEN) @(posedge clk);
    if (pending_beats.size() != 0) begin
      note_mismatch($sformatf("%0d frame bytes never arrived", pending_beats.size()));
    end
    $display("Sent %0d bytes under %0d register writes, %0d drain pauses;",
             rx_count, reg_writes, drain_pauses);
    $display("checked %0d frame bytes in %0d good frames, %0d mismatches.",
             beats_checked, frames_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
